// ----- hw/rtl/mlpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mlpt_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int ENTRY_BITS = 33;
  localparam int NUM_REGS   = 4;

  // configuration register indexes
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] REG_BITS_LEVEL0 = 3'd1;
  localparam logic [2:0] REG_BITS_LEVEL1 = 3'd2;
  localparam logic [2:0] REG_BITS_LEVEL2 = 3'd3;
  localparam logic [2:0] REG_BITS_LEVEL3 = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_MAPPED = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ROOT  = 8'b0000_0100,
    S_ADDR  = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_ALLOC = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // level width clamped to 1..16
  function automatic logic [4:0] eff_bits(input logic [4:0] raw);
    logic [4:0] b;
    b = raw;
    if (b == 5'd0) b = 5'd1;
    if (b > 5'd16) b = 5'd16;
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mlpt_adder.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mlpt_adder (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [32:0] limit,
  output logic      [32:0] sum,
  output logic             fits
);

  // shared adder: slot address or allocator bump, plus fit compare
  assign sum  = {1'b0, a} + {1'b0, b};
  assign fits = (sum <= limit);

endmodule
`default_nettype wire

// ----- hw/rtl/mlpt_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mlpt_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire mlpt_pkg::entry_t      wdata,
  input  wire logic [AW-1:0]         raddr,
  output mlpt_pkg::entry_t           rdata
);

  mlpt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/multi_level_page_table.sv -----
// multi_level_page_table: radix page table walker over 32-bit logical addresses
// input channel s_*: s_tuser is the operation (0 lookup, 1 insert), s_tdata holds
//   the logical address and the frame number to record on insert
// output channel m_*: one result item per input item with hit, status, the frame
//   and the physical address (frame shifted by the offset width, plus offset)
// config port cfg_*: level count and per-level index widths, written while idle
// walk: each level walked takes an address add, a store read and a check, plus an
//   allocator step for each node created, a root creation step and a step to
//   load the output register
// input side: s_tready comes back as the result is loaded into the output
//   register; the single store read port and the shared adder serve one walk at
//   a time, so s_tready is low while a walk runs
// reset: control and config registers go to their defaults, then a clearing pass
//   writes every store entry invalid, one per cycle; no item is taken during it,
//   config writes are taken as ever
// a finished result waits in the output register while m_tready is low; the
//   next item is accepted meanwhile and stalls only at its own result
// TABLE_WORDS must be a power of two
`timescale 1ns / 1ps
`default_nettype none
module multi_level_page_table #(
  parameter int MAX_LEVELS  = 4,
  parameter int TABLE_WORDS = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // logical_address[31:0], frame_number[63:32]
  input  wire logic        s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // frame_out[31:0], physical_address[63:32]
  output logic      [2:0]  m_tuser,   // hit[0], status[2:1]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int AW = $clog2(TABLE_WORDS);

  mlpt_pkg::state_t state;

  // configuration
  logic [2:0] level_count;
  logic [4:0] bits_level [mlpt_pkg::NUM_REGS];

  // item being walked
  logic        func_q;
  logic [31:0] addr_q;
  logic [31:0] frame_q;
  logic [1:0]  lvl;
  logic [31:0] node;
  logic [AW-1:0] slot;
  logic [AW:0]   alloc;
  logic [AW-1:0] clr_addr;

  // pending result
  logic        res_hit;
  logic [31:0] res_frame;
  logic [1:0]  res_status;

  // effective split
  logic [4:0] eb [mlpt_pkg::NUM_REGS];
  logic [6:0] cum [mlpt_pkg::NUM_REGS];
  logic [2:0] nlev;
  logic [6:0] total;
  logic [5:0] offw;
  logic       last;

  always_comb begin
    for (int i = 0; i < mlpt_pkg::NUM_REGS; i++) eb[i] = mlpt_pkg::eff_bits(bits_level[i]);
    cum[0] = {2'b00, eb[0]};
    for (int i = 1; i < mlpt_pkg::NUM_REGS; i++) cum[i] = cum[i-1] + {2'b00, eb[i]};
    nlev = level_count;
    if (nlev == 3'd0) nlev = 3'd1;
    if (nlev > 3'd4) nlev = 3'd4;
    if (32'(nlev) > 32'(MAX_LEVELS)) nlev = 3'(MAX_LEVELS);
    total = cum[2'(nlev - 3'd1)];
    offw  = (total >= 7'd32) ? 6'd0 : 6'(7'd32 - total);
    last  = ({1'b0, lvl} == (nlev - 3'd1));
  end

  // index of the current level: address followed by zeros, taken from the top
  logic [63:0] ext_shift;
  logic [15:0] idx_mask;
  logic [15:0] idx;
  always_comb begin
    ext_shift = {addr_q, 32'd0} >> (7'd64 - cum[lvl]);
    idx_mask  = 16'(17'((17'd1 << eb[lvl]) - 17'd1));
    idx       = ext_shift[15:0] & idx_mask;
  end

  // shared adder operands
  logic [1:0]  size_lvl;
  logic [16:0] blk_size;
  logic [31:0] add_a, add_b;
  logic [32:0] add_sum;
  logic        add_fits;

  always_comb begin
    size_lvl = (state == mlpt_pkg::S_ROOT) ? 2'd0 : lvl + 2'd1;
    blk_size = 17'd1 << eb[size_lvl];
    if (state == mlpt_pkg::S_ADDR) begin
      add_a = node;
      add_b = {16'd0, idx};
    end else begin
      add_a = 32'(alloc);
      add_b = {15'd0, blk_size};
    end
  end

  mlpt_adder u_adder (
    .a     (add_a),
    .b     (add_b),
    .limit (33'(TABLE_WORDS)),
    .sum   (add_sum),
    .fits  (add_fits)
  );

  // entry store
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  mlpt_pkg::entry_t st_wdata;
  mlpt_pkg::entry_t st_rdata;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = slot;
    st_wdata = '0;
    case (state)
      mlpt_pkg::S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_addr;
      end
      mlpt_pkg::S_CHECK: begin
        // leaf write on insert when the entry is still free
        st_we    = (func_q == mlpt_pkg::FUNC_INSERT) && last && !st_rdata[32];
        st_wdata = {1'b1, frame_q};
      end
      mlpt_pkg::S_ALLOC: begin
        st_we    = add_fits;
        st_wdata = {1'b1, 32'(alloc)};
      end
      default: st_we = 1'b0;
    endcase
  end

  mlpt_store #(.DEPTH(TABLE_WORDS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (slot),
    .rdata (st_rdata)
  );

  assign s_tready = (state == mlpt_pkg::S_IDLE);

  // configuration writes, taken in any state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count   <= 3'd3;
      bits_level[0] <= 5'd8;
      bits_level[1] <= 5'd8;
      bits_level[2] <= 5'd8;
      bits_level[3] <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        mlpt_pkg::REG_LEVEL_COUNT: level_count   <= cfg_data[2:0];
        mlpt_pkg::REG_BITS_LEVEL0: bits_level[0] <= cfg_data;
        mlpt_pkg::REG_BITS_LEVEL1: bits_level[1] <= cfg_data;
        mlpt_pkg::REG_BITS_LEVEL2: bits_level[2] <= cfg_data;
        mlpt_pkg::REG_BITS_LEVEL3: bits_level[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mlpt_pkg::S_CLEAR;
      clr_addr <= '0;
      alloc    <= '0;
      lvl      <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (m_tvalid && m_tready && state != mlpt_pkg::S_DONE) m_tvalid <= 1'b0;
      case (state)
        mlpt_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) state <= mlpt_pkg::S_IDLE;
        end
        mlpt_pkg::S_IDLE: begin
          if (s_tvalid) begin
            func_q  <= s_tuser;
            addr_q  <= s_tdata[31:0];
            frame_q <= s_tdata[63:32];
            lvl     <= 2'd0;
            node    <= 32'd0;
            if (alloc == '0) begin
              if (s_tuser == mlpt_pkg::FUNC_INSERT) begin
                state <= mlpt_pkg::S_ROOT;
              end else begin
                res_hit    <= 1'b0;
                res_frame  <= 32'd0;
                res_status <= mlpt_pkg::ST_MISS;
                state      <= mlpt_pkg::S_DONE;
              end
            end else begin
              state <= mlpt_pkg::S_ADDR;
            end
          end
        end
        mlpt_pkg::S_ROOT: begin
          if (add_fits) begin
            alloc <= add_sum[AW:0];
            state <= mlpt_pkg::S_ADDR;
          end else begin
            res_hit    <= 1'b0;
            res_frame  <= 32'd0;
            res_status <= mlpt_pkg::ST_FULL;
            state      <= mlpt_pkg::S_DONE;
          end
        end
        mlpt_pkg::S_ADDR: begin
          slot  <= add_sum[AW-1:0];
          state <= mlpt_pkg::S_READ;
        end
        mlpt_pkg::S_READ: state <= mlpt_pkg::S_CHECK;
        mlpt_pkg::S_CHECK: begin
          if (func_q == mlpt_pkg::FUNC_LOOKUP) begin
            if (!st_rdata[32]) begin
              res_hit    <= 1'b0;
              res_frame  <= 32'd0;
              res_status <= mlpt_pkg::ST_MISS;
              state      <= mlpt_pkg::S_DONE;
            end else if (last) begin
              res_hit    <= 1'b1;
              res_frame  <= st_rdata[31:0];
              res_status <= mlpt_pkg::ST_OK;
              state      <= mlpt_pkg::S_DONE;
            end else begin
              node  <= st_rdata[31:0];
              lvl   <= lvl + 2'd1;
              state <= mlpt_pkg::S_ADDR;
            end
          end else if (last) begin
            res_hit    <= 1'b1;
            res_frame  <= st_rdata[32] ? st_rdata[31:0] : frame_q;
            res_status <= st_rdata[32] ? mlpt_pkg::ST_MAPPED : mlpt_pkg::ST_OK;
            state      <= mlpt_pkg::S_DONE;
          end else if (st_rdata[32]) begin
            node  <= st_rdata[31:0];
            lvl   <= lvl + 2'd1;
            state <= mlpt_pkg::S_ADDR;
          end else begin
            state <= mlpt_pkg::S_ALLOC;
          end
        end
        mlpt_pkg::S_ALLOC: begin
          // child node for the next level from the bump allocator
          if (add_fits) begin
            node  <= 32'(alloc);
            alloc <= add_sum[AW:0];
            lvl   <= lvl + 2'd1;
            state <= mlpt_pkg::S_ADDR;
          end else begin
            res_hit    <= 1'b0;
            res_frame  <= 32'd0;
            res_status <= mlpt_pkg::ST_FULL;
            state      <= mlpt_pkg::S_DONE;
          end
        end
        mlpt_pkg::S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            m_tdata[31:0] <= res_frame;
            m_tdata[63:32] <= res_hit ?
                ((res_frame << offw) | (addr_q & ~(32'hFFFF_FFFF << offw))) : 32'd0;
            m_tuser       <= {res_status, res_hit};
            state         <= mlpt_pkg::S_IDLE;
          end
        end
        default: state <= mlpt_pkg::S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == mlpt_pkg::S_CLEAR) |-> !s_tready)
    else $error("item accepted during clearing pass");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    32'(alloc) <= 32'(TABLE_WORDS))
    else $error("allocator past end of store");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 64'd0))
    else $error("result without hit carries data");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == mlpt_pkg::S_ADDR) |-> ({1'b0, lvl} < nlev))
    else $error("walk beyond configured levels");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_multi_level_page_table.sv -----
`timescale 1ns / 1ps
module tb_multi_level_page_table;

  localparam int STORE_WORDS = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PHASES  = 6;

  // one translation result as the block reports it
  typedef struct packed {
    logic        hit;
    logic [31:0] frame;
    logic [31:0] phys;
    logic [1:0]  status;
  } xlate_t;

  // shadow page table: predicts each translation and holds the pending ones
  class xlate_board;
    logic [32:0] store [STORE_WORDS];
    int          alloc_ptr;
    logic [2:0]  lvl_cfg;
    logic [4:0]  bits_cfg [4];
    xlate_t      pending [$];
    int          errors, results, hits, fulls, mapped;

    function new();
      foreach (store[i]) store[i] = '0;
      alloc_ptr = 0;
      lvl_cfg = 3'd3;
      bits_cfg[0] = 5'd8; bits_cfg[1] = 5'd8; bits_cfg[2] = 5'd8; bits_cfg[3] = 5'd4;
    endfunction

    function void set_reg(logic [2:0] idx, logic [4:0] val);
      if (idx == mlpt_pkg::REG_LEVEL_COUNT) lvl_cfg = val[2:0];
      else if (idx >= mlpt_pkg::REG_BITS_LEVEL0 && idx <= mlpt_pkg::REG_BITS_LEVEL3)
        bits_cfg[idx - mlpt_pkg::REG_BITS_LEVEL0] = val;
    endfunction

    function int width_of(int lvl);
      int b;
      b = bits_cfg[lvl];
      if (b < 1) b = 1;
      if (b > 16) b = 16;
      return b;
    endfunction

    function int depth();
      int n;
      n = lvl_cfg;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      return n;
    endfunction

    function int offset_width();
      int total;
      total = 0;
      for (int i = 0; i < depth(); i++) total += width_of(i);
      return (total >= 32) ? 0 : 32 - total;
    endfunction

    // index bits below bit 0 read as zero
    function int index_of(logic [31:0] addr, int lvl);
      int cum;
      logic [63:0] ext;
      cum = 0;
      for (int i = 0; i <= lvl; i++) cum += width_of(i);
      ext = {addr, 32'd0};
      return int'((ext >> (64 - cum)) & ((64'd1 << width_of(lvl)) - 64'd1));
    endfunction

    function bit grab_node(int lvl, output int base);
      int sz;
      sz = 1 << width_of(lvl);
      if (alloc_ptr + sz > STORE_WORDS) return 0;
      base = alloc_ptr;
      alloc_ptr += sz;
      return 1;
    endfunction

    function void push(logic hit, logic [31:0] frame, logic [31:0] addr, logic [1:0] st);
      xlate_t r;
      logic [63:0] wide;
      int ow;
      ow = offset_width();
      r.hit = hit;
      r.status = st;
      r.frame = hit ? frame : 32'd0;
      wide = ({32'd0, frame} << ow) + ({32'd0, addr} & ((64'd1 << ow) - 64'd1));
      r.phys = hit ? wide[31:0] : 32'd0;
      pending = {pending, r};
    endfunction

    // accepted input item: walk the shadow table
    function void note_request(logic fn, logic [31:0] addr, logic [31:0] frame);
      int node, n, s, b;
      logic [32:0] e;
      node = 0;
      n = depth();
      if (fn == mlpt_pkg::FUNC_LOOKUP) begin
        if (alloc_ptr == 0) begin
          push(0, 0, addr, mlpt_pkg::ST_MISS);
          return;
        end
        for (int i = 0; i < n; i++) begin
          e = store[(node + index_of(addr, i)) % STORE_WORDS];
          if (!e[32]) begin
            push(0, 0, addr, mlpt_pkg::ST_MISS);
            return;
          end
          if (i == n - 1) begin
            push(1, e[31:0], addr, mlpt_pkg::ST_OK);
            return;
          end
          node = int'(e[31:0] % STORE_WORDS);
        end
        return;
      end
      if (alloc_ptr == 0 && !grab_node(0, b)) begin
        push(0, 0, addr, mlpt_pkg::ST_FULL);
        return;
      end
      for (int i = 0; i < n; i++) begin
        s = (node + index_of(addr, i)) % STORE_WORDS;
        e = store[s];
        if (i == n - 1) begin
          if (e[32]) push(1, e[31:0], addr, mlpt_pkg::ST_MAPPED);
          else begin
            store[s] = {1'b1, frame};
            push(1, frame, addr, mlpt_pkg::ST_OK);
          end
          return;
        end
        if (!e[32]) begin
          if (!grab_node(i + 1, b)) begin
            push(0, 0, addr, mlpt_pkg::ST_FULL);
            return;
          end
          e = {1'b1, 32'(b)};
          store[s] = e;
        end
        node = int'(e[31:0] % STORE_WORDS);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(xlate_t got);
      xlate_t want;
      results++;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (want.hit) hits++;
      if (want.status == mlpt_pkg::ST_FULL) fulls++;
      if (want.status == mlpt_pkg::ST_MAPPED) mapped++;
      if (got.hit !== want.hit)
        report($sformatf("hit %0b, want %0b", got.hit, want.hit));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.frame !== want.frame)
        report($sformatf("frame %h, want %h", got.frame, want.frame));
      if (got.phys !== want.phys)
        report($sformatf("phys %h, want %h", got.phys, want.phys));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // logical_address[31:0], frame_number[63:32]
  logic        s_tuser = 0;    // func
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;        // frame_out[31:0], physical_address[63:32]
  logic [2:0]  m_tuser;        // hit[0], status[2:1]
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  xlate_board board = new();
  int  cycles = 0;
  int  items_sent = 0;
  bit  hold_go = 0;            // asks the receiver for one long hold-off
  logic hold_off = 0;

  multi_level_page_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog, covers the clearing pass after reset with lots of margin
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall mode, one mode stalls only during the long hold-off
  int stall_mode = 0;
  always @(posedge clk) begin
    xlate_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.hit    = m_tuser[0];
      got.status = m_tuser[2:1];
      got.frame  = m_tdata[31:0];
      got.phys   = m_tdata[63:32];
      board.check_result(got);
    end
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= !hold_off;
      1: m_tready <= !hold_off && ($urandom_range(0, 1) == 0);
      2: m_tready <= !hold_off && ($urandom_range(0, 3) == 0);
      default: m_tready <= !hold_off && ($urandom_range(0, 7) != 0);
    endcase
  end

  // long hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1;
    repeat (400) @(posedge clk);
    hold_off <= 0;
  end

  // sender burst state
  int burst_left = 0;

  task send_item(logic fn, logic [31:0] addr, logic [31:0] frame);
    int gap;
    s_tvalid <= 1;
    s_tuser  <= fn;
    s_tdata  <= {frame, addr};
    do @(posedge clk); while (!s_tready);
    board.note_request(fn, addr, frame);
    items_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // all results in, then room for a walk still running
  task drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // level count, then widths of levels 0..3 per phase; out-of-range values included
  int phase_cfg [NUM_PHASES][5] = '{
    '{3, 8, 8, 8, 4},
    '{4, 2, 3, 1, 4},
    '{0, 0, 1, 1, 1},
    '{7, 4, 4, 4, 4},
    '{2, 31, 17, 16, 16},
    '{4, 16, 16, 16, 16}
  };
  int phase_items [NUM_PHASES] = '{0, 450, 200, 300, 150, 250};

  initial begin
    logic [31:0] pool [12];
    logic [31:0] offmask, addr;
    int          ow;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int r = 0; r < 5; r++) write_reg(3'(r), 5'(phase_cfg[p][r]));
      cfg_we <= 0;
      @(posedge clk);

      if (p == 0) begin
        // lookup before any insert, field extremes, repeat insert, same page hits
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(mlpt_pkg::FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_item(mlpt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(mlpt_pkg::FUNC_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'h0000_00FF, 32'h0);
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'hFFFF_FF00, 32'h0);
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'h1234_5678, 32'h0);
        send_item(mlpt_pkg::FUNC_INSERT, 32'h1234_5678, 32'hA5A5_A5A5);
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'h1234_56FF, 32'h0);
        send_item(mlpt_pkg::FUNC_INSERT, 32'h8000_0000, 32'h0000_0001);
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_item(mlpt_pkg::FUNC_LOOKUP, 32'h8000_0001, 32'h0);
        send_item(mlpt_pkg::FUNC_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
        send_item(mlpt_pkg::FUNC_INSERT, 32'h1234_5600, 32'h8000_0000);
      end else begin
        if (p == 1) hold_go = 1;
        ow = board.offset_width();
        offmask = (ow >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ow) - 32'd1);
        foreach (pool[k]) pool[k] = $urandom();
        for (int i = 0; i < phase_items[p]; i++) begin
          // mostly insert/lookup over a small page set, some random noise
          if ($urandom_range(0, 9) < 8)
            addr = pool[$urandom_range(0, 11)] ^ ($urandom() & offmask);
          else
            addr = $urandom();
          send_item(logic'($urandom_range(0, 1)), addr, $urandom());
        end
      end
      drain();
    end

    $display("run: %0d items over %0d register settings, %0d results", items_sent,
             NUM_PHASES, board.results);
    $display("hits %0d, already mapped %0d, store full %0d", board.hits, board.mapped,
             board.fulls);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
